// ----- rtl/rfcp_pkg.sv -----
// Shared types and codes for the random free cell picker.
`timescale 1ns / 1ps
`default_nettype none
package rfcp_pkg;
    localparam int CFG_W   = 13;
    localparam int COORD_W = 12;

    localparam logic [1:0] CFG_ROW = 2'd0;
    localparam logic [1:0] CFG_COL = 2'd1;

    localparam logic REQ_FLIP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [1:0] ST_FLIPPED = 2'd0;
    localparam logic [1:0] ST_RESET   = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] random_word;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic [1:0]         status;
    } t_res;
endpackage
`default_nettype wire

// ----- rtl/rfcp_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rfcp_div #(
    parameter int N_W = 32,
    parameter int D_W = 17
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot,
    output logic [D_W-1:0]      o_rem
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_r;
    logic [D_W-1:0]   r_d;
    logic             r_done;

    logic [D_W:0]   w_sh;
    logic [D_W+1:0] w_diff;
    logic           w_borrow;
    logic [N_W-1:0] n_q;
    logic [D_W-1:0] n_r;

    assign w_sh     = {r_r, r_q[N_W-1]};
    assign w_diff   = {1'b0, w_sh} - {2'b0, r_d};
    assign w_borrow = w_diff[D_W+1];
    assign n_q      = {r_q[N_W-2:0], ~w_borrow};
    assign n_r      = w_borrow ? w_sh[D_W-1:0] : w_diff[D_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
                r_cnt  <= CNT_W'(N_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_r   <= n_r;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ----- rtl/random_free_cell_picker_top.sv -----
// Top level: sequencer, used map and group count memories of the free cell picker.
// Usage:
//   Raise start with i_req while busy is low; the request is taken at that edge.
//   Exactly one result per request appears on o_res with o_valid high for one cycle.
//   The receiver cannot stall; results must be captured when o_valid is high.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_data write row (0) or column (1) count while
//   idle; each write clears the map with a sweep over all groups (busy high).
//   Steps per request:
//   over capacity or no free cell: the result is registered straight from idle.
//   reset request: memory sweep, one group row a cycle, then a load state.
//   flip: modulo in the shared divider, a walk that skips whole groups, a scan
//   of the target group bit by bit, then the same divider for row and column.
//   One request at a time; busy stays high until the result is out.
//   After reset the grid is 1 by 1 and a clearing sweep over all groups runs.
`timescale 1ns / 1ps
`default_nettype none
module random_free_cell_picker_top #(
    parameter int MAX_CELLS  = 4096,
    parameter int GROUP_SIZE = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire rfcp_pkg::t_req           i_req,
    output logic                          o_valid,
    output rfcp_pkg::t_res                o_res,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_idx,
    input  wire logic [rfcp_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int NUM_GROUPS = (MAX_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int G_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int B_W     = $clog2(GROUP_SIZE);
    localparam int CNT_W   = $clog2(GROUP_SIZE + 1);
    localparam int FREE_W  = $clog2(MAX_CELLS + 1);
    localparam int TOT_W   = 2 * rfcp_pkg::CFG_W;
    localparam int BASE_W  = $clog2(MAX_CELLS + GROUP_SIZE + 1);
    localparam int D_W     = (FREE_W > rfcp_pkg::CFG_W) ? FREE_W : rfcp_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_LOAD, S_MOD, S_GRD, S_GEVAL, S_BITS, S_COORD
    } t_state;

    t_state r_state;
    logic [rfcp_pkg::CFG_W-1:0] r_row, r_col;
    logic [TOT_W-1:0]  r_total;
    logic [FREE_W-1:0] r_free;
    logic [FREE_W-1:0] r_rank;
    logic [G_W-1:0]    r_g;
    logic [G_W-1:0]    r_clr_idx;
    logic              r_clr_reply;
    logic [BASE_W-1:0] r_base;
    logic [B_W-1:0]    r_bit;
    logic [CNT_W-1:0]  r_span;
    logic              r_valid;
    rfcp_pkg::t_res    r_res;

    logic [GROUP_SIZE-1:0] r_map [NUM_GROUPS];
    logic [CNT_W-1:0]      r_cnt [NUM_GROUPS];
    logic [GROUP_SIZE-1:0] r_map_q, r_word;
    logic [CNT_W-1:0]      r_cnt_q, r_gcnt;

    logic              w_over;
    logic [TOT_W-1:0]  w_rest;
    logic [CNT_W-1:0]  w_span;
    logic [CNT_W-1:0]  w_gfree;
    logic              w_found;
    logic [BASE_W-1:0] w_cell;
    logic              w_div_start;
    logic [31:0]       w_div_n;
    logic [D_W-1:0]    w_div_d;
    logic              w_div_done;
    logic [31:0]       w_quot;
    logic [D_W-1:0]    w_rem;
    logic              w_take;

    assign w_take  = start && (r_state == S_IDLE);
    assign w_over  = r_total > TOT_W'(MAX_CELLS);
    assign w_rest  = r_total - TOT_W'(r_base);
    assign w_span  = (w_rest > TOT_W'(GROUP_SIZE)) ? CNT_W'(GROUP_SIZE) : w_rest[CNT_W-1:0];
    assign w_gfree = (r_cnt_q >= w_span) ? '0 : w_span - r_cnt_q;
    assign w_found = (r_state == S_BITS) && !r_word[r_bit] && (r_rank == '0);
    assign w_cell  = r_base + BASE_W'(r_bit);

    always_comb begin
        w_div_start = 1'b0;
        w_div_n     = i_req.random_word;
        w_div_d     = D_W'(r_free);
        if (w_take && !w_over && i_req.req_type == rfcp_pkg::REQ_FLIP && r_free != '0) begin
            w_div_start = 1'b1;
        end else if (w_found) begin
            w_div_start = 1'b1;
            w_div_n     = 32'(w_cell);
            w_div_d     = D_W'(r_col);
        end
    end

    rfcp_div #(.N_W(32), .D_W(D_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        r_total <= r_row * r_col;
        if (r_state == S_CLEAR) begin
            r_map[r_clr_idx] <= '0;
            r_cnt[r_clr_idx] <= '0;
        end else if (w_found) begin
            r_map[r_g] <= r_word | (GROUP_SIZE'(1) << r_bit);
            r_cnt[r_g] <= r_gcnt + 1'b1;
        end
        r_map_q <= r_map[r_g];
        r_cnt_q <= r_cnt[r_g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= rfcp_pkg::CFG_W'(1);
            r_col       <= rfcp_pkg::CFG_W'(1);
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_free      <= '0;
            r_valid     <= 1'b0;
            r_g         <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we && (i_cfg_idx == rfcp_pkg::CFG_ROW || i_cfg_idx == rfcp_pkg::CFG_COL)) begin
                if (i_cfg_idx == rfcp_pkg::CFG_ROW) begin
                    r_row <= i_cfg_data;
                end else begin
                    r_col <= i_cfg_data;
                end
                r_state     <= S_CLEAR;
                r_clr_idx   <= '0;
                r_clr_reply <= 1'b0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (start) begin
                            r_res <= '0;
                            if (w_over) begin
                                r_res.status <= rfcp_pkg::ST_OVER;
                                r_valid      <= 1'b1;
                            end else if (i_req.req_type == rfcp_pkg::REQ_CLEAR) begin
                                r_state     <= S_CLEAR;
                                r_clr_idx   <= '0;
                                r_clr_reply <= 1'b1;
                            end else if (r_free == '0) begin
                                r_res.status <= rfcp_pkg::ST_NOFREE;
                                r_valid      <= 1'b1;
                            end else begin
                                r_state <= S_MOD;
                            end
                        end
                    end
                    S_CLEAR: begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                        if (r_clr_idx == G_W'(NUM_GROUPS - 1)) begin
                            r_state <= S_LOAD;
                        end
                    end
                    S_LOAD: begin
                        r_free  <= w_over ? '0 : r_total[FREE_W-1:0];
                        r_state <= S_IDLE;
                        if (r_clr_reply) begin
                            r_res        <= '0;
                            r_res.status <= rfcp_pkg::ST_RESET;
                            r_valid      <= 1'b1;
                        end
                    end
                    S_MOD: begin
                        if (w_div_done) begin
                            r_rank  <= w_rem[FREE_W-1:0];
                            r_g     <= '0;
                            r_base  <= '0;
                            r_state <= S_GRD;
                        end
                    end
                    S_GRD: begin
                        if (TOT_W'(r_base) >= r_total) begin
                            r_res.status <= rfcp_pkg::ST_NOFREE;
                            r_valid      <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_state <= S_GEVAL;
                        end
                    end
                    S_GEVAL: begin
                        r_span <= w_span;
                        r_gcnt <= r_cnt_q;
                        r_word <= r_map_q;
                        r_bit  <= '0;
                        if (r_rank >= FREE_W'(w_gfree)) begin
                            r_rank <= r_rank - FREE_W'(w_gfree);
                            if (r_g == G_W'(NUM_GROUPS - 1)) begin
                                r_res.status <= rfcp_pkg::ST_NOFREE;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end else begin
                                r_g     <= r_g + 1'b1;
                                r_base  <= r_base + BASE_W'(GROUP_SIZE);
                                r_state <= S_GRD;
                            end
                        end else begin
                            r_state <= S_BITS;
                        end
                    end
                    S_BITS: begin
                        if (w_found) begin
                            r_free  <= r_free - 1'b1;
                            r_state <= S_COORD;
                        end else begin
                            if (!r_word[r_bit]) begin
                                r_rank <= r_rank - 1'b1;
                            end
                            r_bit <= r_bit + 1'b1;
                            if (CNT_W'(r_bit) + 1'b1 >= r_span) begin
                                r_res.status <= rfcp_pkg::ST_NOFREE;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end
                    end
                    S_COORD: begin
                        if (w_div_done) begin
                            r_res.cell_row <= w_quot[rfcp_pkg::COORD_W-1:0];
                            r_res.cell_col <= w_rem[rfcp_pkg::COORD_W-1:0];
                            r_res.status   <= rfcp_pkg::ST_FLIPPED;
                            r_valid        <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ----- tb/sv/random_free_cell_picker_top_tb.sv -----
// Self-checking testbench for the random free cell picker top level.
`timescale 1ns / 1ps
module random_free_cell_picker_top_tb;
    localparam int MAX_CELLS  = 4096;
    localparam int GROUP_SIZE = 64;
    localparam int NUM_GROUPS = MAX_CELLS / GROUP_SIZE;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    rfcp_pkg::t_req             i_req = '0;
    logic                       o_valid;
    rfcp_pkg::t_res             o_res;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_idx = rfcp_pkg::CFG_ROW;
    logic [rfcp_pkg::CFG_W-1:0] i_cfg_data = '0;

    random_free_cell_picker_top #(.MAX_CELLS(MAX_CELLS), .GROUP_SIZE(GROUP_SIZE)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    int unsigned      grid_rows, grid_cols, cells_free;
    bit [MAX_CELLS-1:0] cell_taken;
    int unsigned      group_taken [NUM_GROUPS];
    rfcp_pkg::t_res   pending_res [$];
    int               mismatches = 0;

    function automatic int unsigned grid_size();
        return grid_rows * grid_cols;
    endfunction

    function automatic void clear_grid();
        int unsigned n;
        n = grid_size();
        cell_taken = '0;
        foreach (group_taken[g]) group_taken[g] = 0;
        cells_free = (n > MAX_CELLS) ? 0 : n;
    endfunction

    function automatic rfcp_pkg::t_res pick_cell(rfcp_pkg::t_req rq);
        rfcp_pkg::t_res r;
        int unsigned n, rank, base, span, gfree, c;
        r = '0;
        n = grid_size();
        if (n > MAX_CELLS) begin
            r.status = rfcp_pkg::ST_OVER;
            return r;
        end
        if (rq.req_type == rfcp_pkg::REQ_CLEAR) begin
            clear_grid();
            r.status = rfcp_pkg::ST_RESET;
            return r;
        end
        r.status = rfcp_pkg::ST_NOFREE;
        if (cells_free == 0) return r;
        rank = rq.random_word % cells_free;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            base = g * GROUP_SIZE;
            if (base >= n) break;
            span = n - base;
            if (span > GROUP_SIZE) span = GROUP_SIZE;
            gfree = (group_taken[g] >= span) ? 0 : span - group_taken[g];
            if (rank >= gfree) begin
                rank -= gfree;
                continue;
            end
            for (int i = 0; i < span; i++) begin
                c = base + i;
                if (cell_taken[c]) continue;
                if (rank == 0) begin
                    cell_taken[c] = 1'b1;
                    group_taken[g]++;
                    cells_free--;
                    r.cell_row = rfcp_pkg::COORD_W'(c / grid_cols);
                    r.cell_col = rfcp_pkg::COORD_W'(c % grid_cols);
                    r.status   = rfcp_pkg::ST_FLIPPED;
                    return r;
                end
                rank--;
            end
            break;
        end
        return r;
    endfunction

    // start stays high after acceptance until the next call or drain lowers it
    task automatic send_req(logic kind, logic [31:0] word);
        int gap;
        rfcp_pkg::t_req rq;
        gap = $urandom_range(0, 8);
        rq.req_type    = kind;
        rq.random_word = word;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_res.push_back(pick_cell(rq));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= rfcp_pkg::CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rfcp_pkg::CFG_ROW) grid_rows = val & 13'h1fff;
        else grid_cols = val & 13'h1fff;
        clear_grid();
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_grid(int unsigned r, int unsigned c);
        write_reg(rfcp_pkg::CFG_ROW, r);
        write_reg(rfcp_pkg::CFG_COL, c);
    endtask

    always @(posedge i_clk) begin
        rfcp_pkg::t_res e;
        if (i_rst_n && o_valid) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_res);
            end else begin
                e = pending_res.pop_front();
                if (o_res.cell_row !== e.cell_row || o_res.cell_col !== e.cell_col ||
                    o_res.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp row %0d col %0d st %0d, got row %0d col %0d st %0d",
                                 e.cell_row, e.cell_col, e.status,
                                 o_res.cell_row, o_res.cell_col, o_res.status);
                end
            end
        end
    end

    task automatic test_defaults();
        send_req(rfcp_pkg::REQ_FLIP, 32'hffff_ffff);
        send_req(rfcp_pkg::REQ_FLIP, 32'h0);
        send_req(rfcp_pkg::REQ_CLEAR, 32'h0);
        send_req(rfcp_pkg::REQ_FLIP, 32'h0);
    endtask

    task automatic test_edges();
        set_grid(0, 5);
        send_req(rfcp_pkg::REQ_CLEAR, 32'h1234);
        send_req(rfcp_pkg::REQ_FLIP, 32'h1);
        set_grid(4096, 1);
        send_req(rfcp_pkg::REQ_FLIP, 32'hffff_ffff);
        send_req(rfcp_pkg::REQ_FLIP, 32'h8000_0000);
        send_req(rfcp_pkg::REQ_CLEAR, 32'h0);
        set_grid(1, 4096);
        send_req(rfcp_pkg::REQ_FLIP, 32'h0);
        send_req(rfcp_pkg::REQ_FLIP, 32'hffff_ffff);
        set_grid(8191, 8191);
        send_req(rfcp_pkg::REQ_FLIP, 32'h5);
        send_req(rfcp_pkg::REQ_CLEAR, 32'h5);
        set_grid(65, 64);
        send_req(rfcp_pkg::REQ_FLIP, 32'h0);
        set_grid(3, 3);
        repeat (10) send_req(rfcp_pkg::REQ_FLIP, 32'hffff_ffff);
        send_req(rfcp_pkg::REQ_CLEAR, 32'h0);
        send_req(rfcp_pkg::REQ_FLIP, 32'haaaa_5555);
    endtask

    task automatic test_random();
        int unsigned shapes [6][2] = '{'{1, 1}, '{2, 7}, '{13, 11}, '{64, 64}, '{100, 3},
                                       '{4096, 1}};
        for (int p = 0; p < 12; p++) begin
            int s;
            s = (p < 6) ? p : $urandom_range(0, 5);
            if (p == 9) set_grid($urandom_range(1, 40), $urandom_range(1, 40));
            else set_grid(shapes[s][0], shapes[s][1]);
            repeat (55) begin
                if ($urandom_range(0, 19) == 0) send_req(rfcp_pkg::REQ_CLEAR, $urandom);
                else send_req(rfcp_pkg::REQ_FLIP, $urandom);
            end
        end
        set_grid(1, 1);
    endtask

    initial begin
        grid_rows = 1;
        grid_cols = 1;
        clear_grid();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        test_defaults();
        test_edges();
        test_random();
        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/rfcp_pkg.sv
rtl/rfcp_div.sv
rtl/random_free_cell_picker_top.sv
tb/sv/random_free_cell_picker_top_tb.sv
